[src/sla_pkg.sv]
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types and constants of the serial line assembler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sla_pkg;

   localparam int LINE_DEPTH = 64;
   localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int LEN_W      = 7;
   localparam int CHAR_W     = 8;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;

   localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_CHAR  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;

   typedef struct packed {
      logic take_byte;
      logic clear_line;
      logic start_read;
      logic load_single;
      logic fetch;
   } sla_cmd_type;

   typedef struct packed {
      logic read_single;
      logic out_free;
      logic fetch_ok;
      logic fetch_last;
      logic pipe_valid;
   } sla_stat_type;

endpackage

`default_nettype wire

[src/sla_ram.sv]
// ----------------------------------------------------------------------------
// sla_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/sla_ctrl.sv]
// ----------------------------------------------------------------------------
// sla_ctrl
// Controller: decodes accepted words and sequences the line read out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sla_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic [sla_pkg::CMD_W-1:0]   req_cmd,
   output logic                             req_tready,
   output sla_pkg::sla_cmd_type             cmd,
   input  wire sla_pkg::sla_stat_type       stat
);
   import sla_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SINGLE = 2'd1;
   localparam logic [1:0] S_STREAM = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_cmd)
                  CMD_BYTE: begin
                     cmd.take_byte = 1'b1;
                  end
                  CMD_READ: begin
                     cmd.start_read = 1'b1;
                     state_in       = stat.read_single ? S_SINGLE : S_STREAM;
                  end
                  CMD_CLEAR: begin
                     cmd.clear_line = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SINGLE: begin
            if (stat.out_free && !stat.pipe_valid) begin
               cmd.load_single = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_STREAM: begin
            if (stat.fetch_ok) begin
               cmd.fetch = 1'b1;
               if (stat.fetch_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[src/sla_dp.sv]
// ----------------------------------------------------------------------------
// sla_dp
// Datapath: line store, fill count, line flags, read pipe and output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sla_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sla_pkg::sla_cmd_type          cmd,
   output sla_pkg::sla_stat_type              stat,
   input  wire logic [sla_pkg::CHAR_W-1:0]    rx_byte,
   input  wire logic [sla_pkg::LEN_W-1:0]     read_limit,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic [sla_pkg::CHAR_W-1:0]         out_char,
   output logic [sla_pkg::STATUS_W-1:0]       out_status,
   output logic                               out_last,
   output logic                               out_overflow_seen,
   output logic [sla_pkg::LEN_W-1:0]          out_line_length
);
   import sla_pkg::*;

   // line state
   logic [LEN_W-1:0]    fill_count_ff, fill_count_in;
   logic                line_waiting_ff, line_waiting_in;
   logic                overflow_ff, overflow_in;
   logic                skip_lf_ff, skip_lf_in;

   // read setup
   logic [LEN_W-1:0]    rd_count_ff, rd_len_ff, rd_idx_ff;
   logic [STATUS_W-1:0] rd_status_ff;
   logic                rd_ovf_ff;

   // fetch pipe
   logic                pipe_valid_ff, pipe_valid_in;
   logic                pipe_last_ff, pipe_ovf_ff;
   logic [LEN_W-1:0]    pipe_len_ff;

   // output word
   logic                out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]   out_char_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic                out_last_ff, out_ovf_ff;
   logic [LEN_W-1:0]    out_len_ff;

   logic                no_line;
   logic [LEN_W-1:0]    rd_n;
   logic                is_cr, is_lf;
   logic                store_en;
   logic                out_free;
   logic                load_pipe;
   logic [CHAR_W-1:0]   ram_rdata;

   assign no_line  = (read_limit == '0) || !line_waiting_ff;
   assign rd_n     = (fill_count_ff >= read_limit) ? (read_limit - LEN_W'(1)) : fill_count_ff;
   assign is_cr    = (rx_byte == CH_CR);
   assign is_lf    = (rx_byte == CH_LF);
   assign out_free = !out_valid_ff || rsp_tready;
   assign load_pipe = pipe_valid_ff && out_free;

   assign store_en = cmd.take_byte && !(skip_lf_ff && is_lf) && !line_waiting_ff
                     && !is_cr && !is_lf && (fill_count_ff < LEN_W'(LINE_DEPTH));

   always_comb begin
      stat.read_single = no_line || (rd_n == '0);
      stat.out_free    = out_free;
      stat.fetch_ok    = !pipe_valid_ff || out_free;
      stat.fetch_last  = (LEN_W'(rd_idx_ff + LEN_W'(1)) == rd_count_ff);
      stat.pipe_valid  = pipe_valid_ff;
   end

   sla_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (fill_count_ff[ADDR_W-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd.fetch),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      fill_count_in   = fill_count_ff;
      line_waiting_in = line_waiting_ff;
      overflow_in     = overflow_ff;
      skip_lf_in      = skip_lf_ff;
      if (cmd.take_byte) begin
         skip_lf_in = 1'b0;
         if (!(skip_lf_ff && is_lf) && !line_waiting_ff) begin
            if (is_cr || is_lf) begin
               line_waiting_in = 1'b1;
               skip_lf_in      = is_cr;
            end else if (fill_count_ff < LEN_W'(LINE_DEPTH)) begin
               fill_count_in = fill_count_ff + LEN_W'(1);
            end else begin
               overflow_in = 1'b1;
            end
         end
      end
      if (cmd.clear_line || (cmd.start_read && !no_line)) begin
         fill_count_in   = '0;
         line_waiting_in = 1'b0;
         overflow_in     = 1'b0;
         skip_lf_in      = 1'b0;
      end
   end

   always_comb begin
      pipe_valid_in = pipe_valid_ff;
      if (cmd.fetch) begin
         pipe_valid_in = 1'b1;
      end else if (load_pipe) begin
         pipe_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (load_pipe || cmd.load_single) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff   <= '0;
         line_waiting_ff <= 1'b0;
         overflow_ff     <= 1'b0;
         skip_lf_ff      <= 1'b0;
         pipe_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         fill_count_ff   <= fill_count_in;
         line_waiting_ff <= line_waiting_in;
         overflow_ff     <= overflow_in;
         skip_lf_ff      <= skip_lf_in;
         pipe_valid_ff   <= pipe_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_read) begin
         rd_count_ff  <= rd_n;
         rd_idx_ff    <= '0;
         rd_ovf_ff    <= overflow_ff;
         rd_len_ff    <= no_line ? '0 : fill_count_ff;
         rd_status_ff <= no_line ? ST_NONE : ST_EMPTY;
      end else if (cmd.fetch) begin
         rd_idx_ff <= rd_idx_ff + LEN_W'(1);
      end
      if (cmd.fetch) begin
         pipe_last_ff <= stat.fetch_last;
         pipe_ovf_ff  <= rd_ovf_ff;
         pipe_len_ff  <= rd_len_ff;
      end
      if (load_pipe) begin
         out_char_ff   <= ram_rdata;
         out_status_ff <= ST_CHAR;
         out_last_ff   <= pipe_last_ff;
         out_ovf_ff    <= pipe_ovf_ff;
         out_len_ff    <= pipe_len_ff;
      end else if (cmd.load_single) begin
         out_char_ff   <= '0;
         out_status_ff <= rd_status_ff;
         out_last_ff   <= 1'b1;
         out_ovf_ff    <= rd_ovf_ff;
         out_len_ff    <= rd_len_ff;
      end
   end

   assign rsp_tvalid        = out_valid_ff;
   assign out_char          = out_char_ff;
   assign out_status        = out_status_ff;
   assign out_last          = out_last_ff;
   assign out_overflow_seen = out_ovf_ff;
   assign out_line_length   = out_len_ff;

   // single result never overtakes a pending character
   a_single_order: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_single && pipe_valid_ff))
      else $error("single result loaded while fetch pipe busy");

   // no store write while a read is fetching
   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      !(store_en && cmd.fetch))
      else $error("line store written during read out");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= LEN_W'(LINE_DEPTH))
      else $error("fill count beyond store depth");

   // a read of a waiting line empties it
   a_read_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_read && !no_line) |=> (!line_waiting_ff && fill_count_ff == '0))
      else $error("line not emptied after read");

endmodule

`default_nettype wire

[src/serial_line_assembler.sv]
// ----------------------------------------------------------------------------
// serial_line_assembler
// Builds one text line from received serial bytes and reads it out.
//
// The req channel carries a command in tuser and a received byte and a read
// limit in tdata. Received bytes and clear commands are taken one per cycle
// and give no result. CR or LF ends a line; an LF right after that CR is
// skipped; bytes are dropped while a line waits, and bytes past the store
// depth set the overflow flag.
// A read command gives one or more rsp words, tlast on the final one. A read
// with nothing to hand out loads one word into the output register once the
// output stage is free. A read that copies characters passes each from the line
// store through the fetch pipe register to the output word, one character per
// cycle while rsp is ready, set by the single read port of the line store.
// req_tready is low from the read's acceptance until its last character is fetched.
// A stall on rsp holds the output word and pauses the read out.
// Reset clears the line flags and fill count and empties the output stage;
// store contents stay as they were and are only read after being written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_line_assembler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // rx_byte[7:0], read_limit[14:8], zero[15]
   input  wire logic [1:0]  req_tuser,   // cmd[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // out_char[7:0], overflow_seen[8], line_length[15:9]
   output logic [1:0]       rsp_tuser,   // status[1:0]
   output logic             rsp_tlast
);
   import sla_pkg::*;

   sla_cmd_type         cmd;
   sla_stat_type        stat;
   logic [CHAR_W-1:0]   out_char;
   logic [STATUS_W-1:0] out_status;
   logic                out_last;
   logic                out_overflow_seen;
   logic [LEN_W-1:0]    out_line_length;

   sla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   sla_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .rx_byte           (req_tdata[7:0]),
      .read_limit        (req_tdata[14:8]),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .out_char          (out_char),
      .out_status        (out_status),
      .out_last          (out_last),
      .out_overflow_seen (out_overflow_seen),
      .out_line_length   (out_line_length)
   );

   assign rsp_tdata = {out_line_length, out_overflow_seen, out_char};
   assign rsp_tuser = out_status;
   assign rsp_tlast = out_last;

endmodule

`default_nettype wire
